FILE: sv/d2conv_pkg.sv
// Shared types and constants for the 3x3 streaming convolution block.
// No dependencies; used by direct_2d_convolution_top.
`default_nettype none

package d2conv_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int KROW_W  = 48;
    localparam int SIZE_W  = 11;
    localparam int CTR_W   = 2;
    localparam int PROD_W  = 24;   // |coef * pixel| < 2^23
    localparam int SUM_W   = 28;   // nine products
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 6;
    localparam int NTAPS   = 9;

    localparam logic [KROW_W-1:0] KROW0_RST = 48'h0000_0000_0000;
    localparam logic [KROW_W-1:0] KROW1_RST = 48'h0000_0100_0000;
    localparam logic [KROW_W-1:0] KROW2_RST = 48'h0000_0000_0000;
    localparam logic [CTR_W-1:0]  CENTER_RST = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_RST   = 11'd1024;

    typedef enum logic [2:0] {
        REG_KROW0  = 3'd0,
        REG_KROW1  = 3'd1,
        REG_KROW2  = 3'd2,
        REG_CROW   = 3'd3,
        REG_CCOL   = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6
    } reg_idx_t;

    // center code 3 behaves as 2
    function automatic logic [CTR_W-1:0] eff_center(input logic [CTR_W-1:0] v);
        return (v == 2'd3) ? 2'd2 : v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/d2conv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the contents before a same-edge write.
`default_nettype none

module d2conv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/direct_2d_convolution_top.sv
// 3x3 streaming convolution: line stores, window, multiply/sum pipeline.
// Depends on d2conv_pkg and d2conv_ram.
//
// Usage:
//   Slave stream: one pixel per transaction in raster order (s_tdata),
//   s_tuser = 1 marks a trailing flush transaction (pixel taken as 0).
//   Master stream: one filtered pixel per output (m_tdata), m_tlast on the
//   final pixel of the frame. Output n comes from input transaction
//   n + kc_row*width + kc_col (kernel center); after the frame send that many
//   flush transactions.
//   APB port: kernel rows, center and image size at byte address 8*i.
//   Write only while the block is idle.
// Timing:
//   Four stages (line-store read, products, sum, round/clamp). One input per
//   cycle sustained while m_tready holds high; each stage has its own valid
//   so bubbles fill while the receiver stalls, and s_tready drops only once
//   the pipe is full.
// Reset: aresetn (synchronous) clears counters, window, valids and config
//   to the identity kernel, center (1,1), 1024x1024. Line stores need no
//   clearing: unwritten entries only feed neighbors outside the image.
`default_nettype none

module direct_2d_convolution_top #(
    parameter int MAX_WIDTH  = d2conv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = d2conv_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // slave stream
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [d2conv_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel
    input  wire logic                             s_tuser,   // [0] flush
    // master stream
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [d2conv_pkg::PIX_W-1:0]     m_tdata,   // [7:0] filtered_pixel
    output      logic                             m_tlast,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [d2conv_pkg::APB_AW-1:0]    paddr,
    input  wire logic [d2conv_pkg::APB_DW-1:0]    pwdata,
    output      logic [d2conv_pkg::APB_DW-1:0]    prdata,
    output      logic                             pready
);

    import d2conv_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int IRW = RW + 2;
    localparam int EW  = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int EH  = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

    // ---------------- configuration ----------------
    logic [KROW_W-1:0] krow_reg [3];
    logic [CTR_W-1:0]  crow_reg, ccol_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            krow_reg[0] <= KROW0_RST;
            krow_reg[1] <= KROW1_RST;
            krow_reg[2] <= KROW2_RST;
            crow_reg    <= CENTER_RST;
            ccol_reg    <= CENTER_RST;
            width_reg   <= SIZE_RST;
            height_reg  <= SIZE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KROW0:  krow_reg[0] <= pwdata[KROW_W-1:0];
                REG_KROW1:  krow_reg[1] <= pwdata[KROW_W-1:0];
                REG_KROW2:  krow_reg[2] <= pwdata[KROW_W-1:0];
                REG_CROW:   crow_reg    <= pwdata[CTR_W-1:0];
                REG_CCOL:   ccol_reg    <= pwdata[CTR_W-1:0];
                REG_WIDTH:  width_reg   <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_KROW0:  prdata = APB_DW'(krow_reg[0]);
            REG_KROW1:  prdata = APB_DW'(krow_reg[1]);
            REG_KROW2:  prdata = APB_DW'(krow_reg[2]);
            REG_CROW:   prdata = APB_DW'(crow_reg);
            REG_CCOL:   prdata = APB_DW'(ccol_reg);
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // effective sizes and centre
    logic [EW-1:0]    w_eff;
    logic [EH-1:0]    h_eff;
    logic [CTR_W-1:0] cr, cc;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = EW'(1);
        end else if (EW'(width_reg) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = EH'(1);
        end else if (EH'(height_reg) > EH'(MAX_HEIGHT)) begin
            h_eff = EH'(MAX_HEIGHT);
        end else begin
            h_eff = EH'(height_reg);
        end
        cr = eff_center(crow_reg);
        cc = eff_center(ccol_reg);
    end

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_emit_reg;
    logic s1_adv, s2_adv, s3_adv;
    logic s2_ready, s3_ready, out_ready;
    logic acc;

    assign out_ready = !m_tvalid || m_tready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_adv    = s1_valid_reg && (!s1_emit_reg || s2_ready);
    assign s2_adv    = s2_valid_reg && s3_ready;
    assign s3_adv    = s3_valid_reg && out_ready;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign acc       = s_tvalid && s_tready;

    // ---------------- position counters (accept stage) ----------------
    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [IRW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic           acc_emit, acc_last, in_wrap, out_wrap;
    logic [2:0]     acc_row_ok, acc_col_ok;
    logic [EH:0]    r_pos;
    logic [EW:0]    c_pos;
    logic [PIX_W-1:0] acc_cur;

    always_comb begin
        acc_cur  = s_tuser ? '0 : s_tdata;
        acc_emit = (in_row_reg > IRW'(cr))
                || ((in_row_reg == IRW'(cr)) && (in_col_reg >= CW'(cc)));
        in_wrap  = (EW'(in_col_reg) + EW'(1)) >= w_eff;
        out_wrap = (EW'(out_col_reg) + EW'(1)) >= w_eff;
        acc_last = ((EH'(out_row_reg) + EH'(1)) >= h_eff) && out_wrap;
        r_pos    = (EH+1)'(out_row_reg) + (EH+1)'(cr);
        c_pos    = (EW+1)'(out_col_reg) + (EW+1)'(cc);
        for (int a = 0; a < 3; a++) begin
            acc_row_ok[a] = (r_pos >= (EH+1)'(a))
                         && ((r_pos - (EH+1)'(a)) < (EH+1)'(h_eff));
            acc_col_ok[a] = (c_pos >= (EW+1)'(a))
                         && ((c_pos - (EW+1)'(a)) < (EW+1)'(w_eff));
        end

        in_col_next  = in_wrap ? '0 : in_col_reg + CW'(1);
        in_row_next  = in_wrap ? in_row_reg + IRW'(1) : in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (acc_emit) begin
            if (acc_last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                out_col_next = out_wrap ? '0 : out_col_reg + CW'(1);
                out_row_next = out_wrap ? out_row_reg + RW'(1) : out_row_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (acc) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- line stores: one RAM per row parity ----------------
    logic [PIX_W-1:0] ram0_rd, ram1_rd;
    logic             acc_par;

    assign acc_par = in_row_reg[0];

    d2conv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line0 (
        .aclk  (aclk),
        .we    (acc && !acc_par),
        .waddr (in_col_reg),
        .wdata (acc_cur),
        .re    (acc),
        .raddr (in_col_reg),
        .rdata (ram0_rd)
    );

    d2conv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
        .aclk  (aclk),
        .we    (acc && acc_par),
        .waddr (in_col_reg),
        .wdata (acc_cur),
        .re    (acc),
        .raddr (in_col_reg),
        .rdata (ram1_rd)
    );

    // ---------------- stage 1: line-store data, window update ----------------
    logic [PIX_W-1:0] s1_cur_reg;
    logic             s1_par_reg, s1_last_reg;
    logic [2:0]       s1_row_ok_reg, s1_col_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_cur_reg    <= acc_cur;
            s1_par_reg    <= acc_par;
            s1_emit_reg   <= acc_emit;
            s1_last_reg   <= acc_last;
            s1_row_ok_reg <= acc_row_ok;
            s1_col_ok_reg <= acc_col_ok;
        end
    end

    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] win_new [3][3];

    always_comb begin
        win_new[0][0] = s1_cur_reg;
        win_new[1][0] = s1_par_reg ? ram0_rd : ram1_rd;   // row above
        win_new[2][0] = s1_par_reg ? ram1_rd : ram0_rd;   // two rows above
        for (int a = 0; a < 3; a++) begin
            win_new[a][1] = win_reg[a][0];
            win_new[a][2] = win_reg[a][1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    win_reg[a][b] <= '0;
                end
            end
        end else if (s1_adv) begin
            win_reg <= win_new;
        end
    end

    // ---------------- stage 2: nine products ----------------
    logic signed [PROD_W-1:0] prod_reg  [NTAPS];
    logic signed [PROD_W-1:0] prod_next [NTAPS];
    logic                     s2_last_reg;

    always_comb begin
        logic signed [COEF_W-1:0] coef;
        logic signed [PROD_W-1:0] c_ext, p_ext;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                coef  = krow_reg[a][COEF_W*b +: COEF_W];
                c_ext = PROD_W'(coef);
                p_ext = PROD_W'(win_new[a][b]);
                prod_next[3*a+b] = (s1_row_ok_reg[a] && s1_col_ok_reg[b])
                                 ? c_ext * p_ext : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_adv && s1_emit_reg) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_adv) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            prod_reg    <= prod_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ---------------- stage 3: sum ----------------
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    s3_last_reg;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NTAPS; i++) begin
            sum_next = sum_next + SUM_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            sum_reg     <= sum_next;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------- output: round half up, clamp to 0..255 ----------------
    logic [SUM_W-1:0]   rnd;
    logic [SUM_W-9:0]   scaled;
    logic [PIX_W-1:0]   pix_next;

    always_comb begin
        rnd    = sum_reg + SUM_W'(128);
        scaled = rnd[SUM_W-1:8];
        if (sum_reg[SUM_W-1]) begin
            pix_next = '0;
        end else if (scaled > (SUM_W-8)'(255)) begin
            pix_next = '1;
        end else begin
            pix_next = scaled[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_ready) begin
            m_tvalid <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_adv) begin
            m_tdata <= pix_next;
            m_tlast <= s3_last_reg;
        end
    end

`ifndef ASSERT_OFF
    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && acc_emit && acc_last) |=>
            (in_col_reg == '0 && in_row_reg == '0
             && out_col_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after last output");

    a_out_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s3_valid_reg))
        else $error("output valid without a summed transaction");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s_tready) |=> ($stable(s1_cur_reg) && $stable(s1_emit_reg)))
        else $error("stage 1 payload changed while stalled");

    a_emit_only_to_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && !s1_emit_reg && !s2_valid_reg) |=> !s2_valid_reg)
        else $error("non-emitting transaction entered product stage");
`endif

endmodule

`default_nettype wire
